[rtl/fslp_pkg.sv]
// Package with shared types, codes and constants of the fuel sensor line parser.
`timescale 1ns / 1ps
package fslp_pkg;

   localparam logic [7:0] LINE_END  = 8'h0d;
   localparam logic [7:0] SEP_COMMA = 8'h2c;
   localparam logic [7:0] SEP_HASH  = 8'h23;

   localparam logic [1:0] ST_DISCONNECTED = 2'd0;
   localparam logic [1:0] ST_NORMAL       = 2'd1;
   localparam logic [1:0] ST_ABNORMAL     = 2'd2;

   localparam logic [2:0] RES_NONE   = 3'd0;
   localparam logic [2:0] RES_GOOD   = 3'd1;
   localparam logic [2:0] RES_BAD    = 3'd2;
   localparam logic [2:0] RES_ABORT  = 3'd3;
   localparam logic [2:0] RES_NOSUM  = 3'd4;

   localparam logic [1:0] CSR_SPEED   = 2'd0;
   localparam logic [1:0] CSR_ABN     = 2'd1;
   localparam logic [1:0] CSR_ZERO    = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT = 2'd3;

   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [7:0] AVG_FIELD  = 8'd4;
   localparam logic [7:0] RT_FIELD   = 8'd10;
   localparam logic [7:0] SUM_FIELD  = 8'd12;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  rx_byte;
      logic [15:0] vehicle_speed;
   } req_type;

   typedef struct packed {
      logic [16:0] fuel_level;
      logic [16:0] average_level;
      logic [16:0] realtime_level;
      logic [1:0]  sensor_state;
      logic        fuel_alarm;
      logic [2:0]  frame_result;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_SCAN,
      S_FRAME,
      S_DONE
   } ctl_state_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic store_byte;
      logic tick;
      logic clear_scan;
      logic sum_step;
      logic scan_step;
      logic good_frame;
      logic clear_line;
      logic emit;
   } cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic sum_done;
      logic scan_done;
      logic abort;
      logic sum_hit;
   } sts_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) n = 4'(c - 8'h37);
      else if (c >= 8'h61 && c <= 8'h66) n = 4'(c - 8'h57);
      return n;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

[rtl/fuel_sensor_line_parser.sv]
// Top level of the fuel sensor line parser.
`timescale 1ns / 1ps
// Usage:
// The req_ channel carries one word per command: a received UART byte
// (cmd 0) or a one-second tick (cmd 1). A word is taken at a rising edge
// where start is high and busy is low. Every word yields one result word,
// shown on rsp_ for exactly one cycle while rsp_valid is high.
// A tick or an ordinary byte is answered through the emit and response
// registers, and busy stays low, so such words may come back to back.
// A carriage return starts the line parse: a checksum pass over the first
// CHECK_SPAN bytes, then a field scan from SCAN_START to the line end, one
// stored byte per cycle through the line RAM read port, held for the
// good-frame update after a checksum match. busy is high while the parse
// runs, from the checksum pass through the done state.
// Reset (synchronous, active high) empties the line, zeroes the levels and
// counters, marks the sensor disconnected and loads the default settings.
// The line RAM itself is not cleared; only written bytes are ever read.
// The receiver cannot stall; it must take each result word when shown.
// csr_ writes take effect at once. The user must make them only while the
// block is idle; the block itself does not enforce this.
module fuel_sensor_line_parser #(
   parameter int LINE_DEPTH = 128,
   parameter int CHECK_SPAN = 52,
   parameter int FIELD_MAX  = 32,
   parameter int SCAN_START = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  fslp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output fslp_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [fslp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fslp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   fslp_pkg::cmd_type cmd;
   fslp_pkg::sts_type sts;

   fslp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_data),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   fslp_dp #(
      .LINE_DEPTH (LINE_DEPTH),
      .CHECK_SPAN (CHECK_SPAN),
      .FIELD_MAX  (FIELD_MAX),
      .SCAN_START (SCAN_START)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );
endmodule

[rtl/fslp_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module fslp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/fslp_ctrl.sv]
// Controller state machine of the fuel sensor line parser.
`timescale 1ns / 1ps
module fslp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  fslp_pkg::req_type req,
   input  fslp_pkg::sts_type sts,
   output fslp_pkg::cmd_type cmd,
   output logic              busy
);
   fslp_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fslp_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != fslp_pkg::S_IDLE);
      unique case (state_ff)
         fslp_pkg::S_IDLE: begin
            if (start) begin
               if (req.cmd) begin
                  cmd.tick = 1'b1;
                  cmd.emit = 1'b1;
               end else if (req.rx_byte != fslp_pkg::LINE_END) begin
                  cmd.store_byte = 1'b1;
                  cmd.emit = 1'b1;
               end else begin
                  cmd.clear_scan = 1'b1;
                  state_in = fslp_pkg::S_SUM;
               end
            end
         end
         fslp_pkg::S_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_done) state_in = fslp_pkg::S_SCAN;
         end
         fslp_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.abort || sts.scan_done) state_in = fslp_pkg::S_DONE;
            else if (sts.sum_hit) state_in = fslp_pkg::S_FRAME;
         end
         fslp_pkg::S_FRAME: begin
            cmd.good_frame = 1'b1;
            state_in = fslp_pkg::S_SCAN;
         end
         fslp_pkg::S_DONE: begin
            cmd.clear_line = 1'b1;
            cmd.emit = 1'b1;
            state_in = fslp_pkg::S_IDLE;
         end
         default: state_in = fslp_pkg::S_IDLE;
      endcase
   end
endmodule

[rtl/fslp_dp.sv]
// Datapath of the fuel sensor line parser: line store, checksum, field scan and level state.
`timescale 1ns / 1ps
module fslp_dp #(
   parameter int LINE_DEPTH = 128,
   parameter int CHECK_SPAN = 52,
   parameter int FIELD_MAX  = 32,
   parameter int SCAN_START = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fslp_pkg::req_type                   req,
   input  fslp_pkg::cmd_type                   cmd,
   input  logic                                csr_wr_en,
   input  logic [fslp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fslp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output fslp_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   output fslp_pkg::rsp_type                   rsp
);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int LW = $clog2(LINE_DEPTH + 1);
   localparam int FW = $clog2(FIELD_MAX + 1);

   logic [15:0] speed_thr_ff;
   logic [4:0]  abn_lim_ff, zero_lim_ff;
   logic [7:0]  timeout_ff;

   logic [LW-1:0] len_ff;
   logic [16:0]   avg_ff, rt_ff, acc_ff;
   logic [1:0]    wstate_ff;
   logic [7:0]    silence_ff;
   logic [4:0]    abn_ff, zero_ff;
   logic          alarm_ff;

   // Scan bookkeeping. The byte read at the address is on the RAM data in the cycle after.
   logic [LW-1:0] addr_ff;
   logic          rd_valid_ff;
   logic [LW-1:0] rd_pos_ff;
   logic [7:0]    sum_ff;
   logic [FW-1:0] count_ff;
   logic [7:0]    seps_ff;
   logic [16:0]   acc5_ff;
   logic          dig_ok_ff;
   logic [3:0]    hi_ff, lo_ff;
   logic [2:0]    result_ff;
   logic [15:0]   speed_ff;
   logic          emit_ff;
   logic          done_ff;
   logic [7:0]    rd_data;
   logic [AW-1:0] ram_rd_addr;

   fslp_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.store_byte && (len_ff < LW'(LINE_DEPTH))),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (req.rx_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );
   // The first checksum byte is fetched while the line end is taken, and the
   // pending scan byte is fetched again during the frame update.
   assign ram_rd_addr = cmd.clear_scan ? '0 :
                        cmd.good_frame ? rd_pos_ff[AW-1:0] : addr_ff[AW-1:0];

   localparam int SUM_END = (CHECK_SPAN < LINE_DEPTH) ? CHECK_SPAN : LINE_DEPTH;

   logic is_sep, in_sum, in_line;
   logic [7:0] seps_n;
   assign is_sep  = (rd_data == fslp_pkg::SEP_COMMA) || (rd_data == fslp_pkg::SEP_HASH);
   assign in_sum  = rd_valid_ff && (rd_pos_ff < len_ff) && (rd_pos_ff < LW'(SUM_END));
   assign in_line = rd_valid_ff && (rd_pos_ff < len_ff);
   assign seps_n  = (seps_ff == 8'hff) ? seps_ff : seps_ff + 8'd1;

   // The checksum pass ends in the gap cycle that refetches the scan start.
   assign sts.sum_done  = !rd_valid_ff;
   assign sts.scan_done = !rd_valid_ff && addr_ff >= len_ff;
   assign sts.abort = cmd.scan_step && in_line && (
      (!is_sep && (32'(count_ff) + 2 >= FIELD_MAX)) ||
      (is_sep && (seps_n == fslp_pkg::AVG_FIELD || seps_n == fslp_pkg::RT_FIELD) &&
       (count_ff < FW'(5))));
   assign sts.sum_hit = cmd.scan_step && in_line && is_sep && !sts.abort &&
      (seps_n == fslp_pkg::SUM_FIELD) && ({hi_ff, lo_ff} == sum_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_thr_ff <= 16'd100;
         abn_lim_ff   <= 5'd10;
         zero_lim_ff  <= 5'd10;
         timeout_ff   <= 8'd120;
      end else if (csr_wr_en) begin
         case (csr_index)
            fslp_pkg::CSR_SPEED:   speed_thr_ff <= csr_wdata;
            fslp_pkg::CSR_ABN:     abn_lim_ff   <= csr_wdata[4:0];
            fslp_pkg::CSR_ZERO:    zero_lim_ff  <= csr_wdata[4:0];
            fslp_pkg::CSR_TIMEOUT: timeout_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [4:0] abn_inc, zero_inc;
   logic [7:0] sil_inc;
   assign abn_inc  = (abn_ff  == 5'd31) ? abn_ff  : abn_ff  + 5'd1;
   assign zero_inc = (zero_ff == 5'd31) ? zero_ff : zero_ff + 5'd1;
   assign sil_inc  = (silence_ff == 8'hff) ? silence_ff : silence_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; avg_ff <= '0; rt_ff <= '0; acc_ff <= '0;
         wstate_ff <= fslp_pkg::ST_DISCONNECTED; silence_ff <= '0;
         abn_ff <= '0; zero_ff <= '0; alarm_ff <= 1'b0;
         rd_valid_ff <= 1'b0; rsp_valid <= 1'b0; addr_ff <= '0;
         emit_ff <= 1'b0; done_ff <= 1'b0;
         result_ff <= fslp_pkg::RES_NONE;
      end else begin
         emit_ff <= cmd.emit;
         done_ff <= cmd.clear_line;
         rsp_valid <= emit_ff;
         if (cmd.store_byte && len_ff < LW'(LINE_DEPTH)) len_ff <= len_ff + 1'b1;
         if (cmd.tick && wstate_ff != fslp_pkg::ST_DISCONNECTED) begin
            silence_ff <= sil_inc;
            if (sil_inc > timeout_ff) begin
               wstate_ff <= fslp_pkg::ST_DISCONNECTED;
               silence_ff <= '0; abn_ff <= '0; zero_ff <= '0; alarm_ff <= 1'b0;
            end
         end
         if (cmd.clear_scan) begin
            rd_valid_ff <= 1'b1; rd_pos_ff <= '0;
            sum_ff <= '0; count_ff <= '0; seps_ff <= '0;
            acc5_ff <= '0; dig_ok_ff <= 1'b1; hi_ff <= '0; lo_ff <= '0;
            speed_ff <= req.vehicle_speed; result_ff <= fslp_pkg::RES_NOSUM;
            addr_ff <= LW'(1);
         end
         // Checksum pass: one byte per cycle over the first bytes.
         if (cmd.sum_step) begin
            if (in_sum) sum_ff <= sum_ff + rd_data;
            rd_pos_ff <= addr_ff;
            if (addr_ff >= LW'(SUM_END)) begin
               rd_valid_ff <= 1'b0;
               addr_ff <= LW'(SCAN_START);
            end else begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (!rd_valid_ff) begin
               // Restart the read stream at the scan start.
               rd_valid_ff <= 1'b1;
               rd_pos_ff <= LW'(SCAN_START);
               addr_ff <= LW'(SCAN_START + 1);
            end
         end
         // Field scan: one byte per cycle, except while held for the good-frame update.
         if (cmd.scan_step) begin
            if (in_line && !sts.abort) begin
               if (!is_sep) begin
                  count_ff <= count_ff + 1'b1;
                  if (count_ff < FW'(5) && dig_ok_ff) begin
                     if (fslp_pkg::is_digit(rd_data))
                        acc5_ff <= 17'(acc5_ff * 17'd10) + 17'(rd_data - 8'h30);
                     else dig_ok_ff <= 1'b0;
                  end
                  if (count_ff == '0) hi_ff <= fslp_pkg::hex_nibble(rd_data);
                  if (count_ff == FW'(1)) lo_ff <= fslp_pkg::hex_nibble(rd_data);
               end else begin
                  seps_ff <= seps_n;
                  if (seps_n == fslp_pkg::AVG_FIELD) avg_ff <= acc5_ff;
                  if (seps_n == fslp_pkg::RT_FIELD) rt_ff <= acc5_ff;
                  if (seps_n == fslp_pkg::SUM_FIELD)
                     result_ff <= ({hi_ff, lo_ff} == sum_ff) ? fslp_pkg::RES_GOOD
                                                            : fslp_pkg::RES_BAD;
                  count_ff <= '0; acc5_ff <= '0; dig_ok_ff <= 1'b1;
                  hi_ff <= '0; lo_ff <= '0;
               end
            end
            if (sts.abort) result_ff <= fslp_pkg::RES_ABORT;
            rd_pos_ff <= addr_ff;
            if (sts.abort || addr_ff >= len_ff || addr_ff >= LW'(LINE_DEPTH)) begin
               rd_valid_ff <= 1'b0;
            end else begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (!in_line && rd_valid_ff) rd_valid_ff <= 1'b0;
         end
         // Good frame update, in the cycle after the checksum matched.
         if (cmd.good_frame) begin
            silence_ff <= '0;
            if (rt_ff != avg_ff) begin
               acc_ff <= avg_ff;
               if (rt_ff != '0) begin
                  wstate_ff <= fslp_pkg::ST_NORMAL;
                  abn_ff <= '0; zero_ff <= '0; alarm_ff <= 1'b0;
               end else if (wstate_ff == fslp_pkg::ST_NORMAL) begin
                  if (speed_ff > speed_thr_ff) begin
                     abn_ff <= abn_inc;
                     if (abn_inc > abn_lim_ff) begin
                        wstate_ff <= fslp_pkg::ST_ABNORMAL;
                        abn_ff <= '0; alarm_ff <= 1'b1;
                     end
                     zero_ff <= '0;
                  end else if (abn_ff != '0) begin
                     zero_ff <= zero_inc;
                     if (zero_inc > zero_lim_ff) begin
                        zero_ff <= '0; abn_ff <= '0;
                     end
                  end
               end
            end
         end
         if (cmd.clear_line) len_ff <= '0;
      end
   end

   // While stalled for the frame update the RAM output must be re-read:
   // the scan step that matched already advanced the address, so the
   // pending byte is refetched from its position register, rd_pos_ff.
   always_ff @(posedge clock) begin
      rsp.fuel_level     <= acc_ff;
      rsp.average_level  <= avg_ff;
      rsp.realtime_level <= rt_ff;
      rsp.sensor_state   <= wstate_ff;
      rsp.fuel_alarm     <= alarm_ff;
      rsp.frame_result   <= done_ff ? result_ff : fslp_pkg::RES_NONE;
   end

   // Outputs reflect state after the item: tick/byte results come from the
   // updated registers through the registered rsp outputs.
endmodule

[rtl/fslp_checker.sv]
// Port-level assertions for the fuel sensor line parser, bound to the top level.
`timescale 1ns / 1ps
module fslp_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input fslp_pkg::rsp_type rsp_data
);
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sensor_state == fslp_pkg::ST_DISCONNECTED ||
                     rsp_data.sensor_state == fslp_pkg::ST_NORMAL ||
                     rsp_data.sensor_state == fslp_pkg::ST_ABNORMAL))
      else $error("sensor state code out of range");

   a_alarm_abnormal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fuel_alarm |-> rsp_data.sensor_state == fslp_pkg::ST_ABNORMAL)
      else $error("alarm set outside abnormal state");

   a_disc_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sensor_state == fslp_pkg::ST_DISCONNECTED |->
      !rsp_data.fuel_alarm)
      else $error("alarm while disconnected");

   a_line_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_result != fslp_pkg::RES_NONE |-> $past(busy, 2))
      else $error("frame result without a parse");
endmodule

bind fuel_sensor_line_parser fslp_checker u_fslp_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

[test/tb_top.sv]
// Self-checking testbench for the fuel sensor line parser.
`timescale 1ns / 1ps
module tb_top;

   // Block sizes, kept at the defaults of the instance below.
   localparam int LINE_CAP  = 128;
   localparam int SUM_SPAN  = 52;
   localparam int FIELD_CAP = 32;
   localparam int SCAN_FROM = 8;

   // Quiet cycles allowed before the run is declared hung. The limit covers
   // the slowest line end and the settle wait before a settings change.
   localparam int QUIET_LIMIT  = 5000;
   // Settle time after the last result, longer than the slowest line end.
   localparam int SETTLE_CYCLES = 200;
   localparam int WORDS_PER_PHASE = 300;
   localparam int MAX_REPORTS = 10;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   fslp_pkg::req_type req_data;
   logic              rsp_valid;
   fslp_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic [fslp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fslp_pkg::CSR_DATA_W-1:0] csr_wdata;

   fuel_sensor_line_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Predicted state of the parser and its settings.
   // ------------------------------------------------------------------
   logic [7:0]  line_bytes [LINE_CAP];
   int          line_fill;
   logic [16:0] avg_level;
   logic [16:0] rt_level;
   logic [16:0] fuel_level;
   logic [1:0]  sensor_state;
   logic [7:0]  silent_ticks;
   logic [4:0]  abnormal_hits;
   logic [4:0]  slow_zero_hits;
   logic        alarm_bit;

   logic [15:0] speed_limit;
   logic [4:0]  abnormal_max;
   logic [4:0]  zero_clear_max;
   logic [7:0]  silence_max;

   // Words expected back from the block, oldest first.
   fslp_pkg::rsp_type expected_words [$];

   int errors;
   int words_sent;
   int result_seen [8];
   int abnormal_seen;

   // The next word may carry a hand-typed expectation instead of a predicted one.
   bit                use_typed;
   fslp_pkg::rsp_type typed_word;
   // Copies taken on the falling edge that drives the word, read by the monitor.
   bit                drive_typed;
   fslp_pkg::rsp_type drive_word;

   // Percentage of words preceded by an idle gap on the request side.
   int idle_pct;

   // Bytes of the line being built for the next frame.
   logic [7:0] frame_bytes [$];

   function automatic void clear_prediction();
      line_fill      = 0;
      avg_level      = '0;
      rt_level       = '0;
      fuel_level     = '0;
      sensor_state   = fslp_pkg::ST_DISCONNECTED;
      silent_ticks   = '0;
      abnormal_hits  = '0;
      slow_zero_hits = '0;
      alarm_bit      = 1'b0;
      speed_limit    = 16'd100;
      abnormal_max   = 5'd10;
      zero_clear_max = 5'd10;
      silence_max    = 8'd120;
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'd0;
   endfunction

   // State update for a frame whose checksum matched.
   function automatic void apply_good_frame(input logic [15:0] speed);
      silent_ticks = '0;
      if (rt_level == avg_level) return;
      fuel_level = avg_level;
      if (rt_level != 0) begin
         sensor_state   = fslp_pkg::ST_NORMAL;
         abnormal_hits  = '0;
         slow_zero_hits = '0;
         alarm_bit      = 1'b0;
      end else if (sensor_state == fslp_pkg::ST_NORMAL) begin
         if (speed > speed_limit) begin
            // A zero reading while driving fast counts toward the alarm.
            if (abnormal_hits != 5'd31) abnormal_hits++;
            if (abnormal_hits > abnormal_max) begin
               sensor_state  = fslp_pkg::ST_ABNORMAL;
               abnormal_hits = '0;
               alarm_bit     = 1'b1;
            end
            slow_zero_hits = '0;
         end else if (abnormal_hits != 0) begin
            // Zero readings at low speed slowly forgive earlier hits.
            if (slow_zero_hits != 5'd31) slow_zero_hits++;
            if (slow_zero_hits > zero_clear_max) begin
               slow_zero_hits = '0;
               abnormal_hits  = '0;
            end
         end
      end
   endfunction

   // Walks the stored line the way the block does and returns the frame result.
   function automatic logic [2:0] parse_stored_line(input logic [15:0] speed);
      logic [7:0]  fld [FIELD_CAP];
      int          cnt;
      int          seps;
      logic [2:0]  res;
      logic [7:0]  sum;
      logic [7:0]  chk;
      logic [16:0] v;
      bit          stop;
      logic [7:0]  c;
      res  = fslp_pkg::RES_NOSUM;
      cnt  = 0;
      seps = 0;
      sum  = '0;
      for (int k = 0; k < SUM_SPAN; k++)
         if (k < line_fill) sum += line_bytes[k];
      for (int k = SCAN_FROM; k < line_fill; k++) begin
         c = line_bytes[k];
         if (c != fslp_pkg::SEP_COMMA && c != fslp_pkg::SEP_HASH) begin
            fld[cnt] = c;
            cnt++;
            if (cnt + 1 >= FIELD_CAP) return fslp_pkg::RES_ABORT;
         end else begin
            if (seps < 255) seps++;
            if (seps == fslp_pkg::AVG_FIELD || seps == fslp_pkg::RT_FIELD) begin
               if (cnt < 5) return fslp_pkg::RES_ABORT;
               v    = '0;
               stop = 0;
               for (int i = 0; i < 5; i++) begin
                  if (!stop && fld[i] >= "0" && fld[i] <= "9") v = v * 10 + (fld[i] - "0");
                  else stop = 1;
               end
               if (seps == fslp_pkg::AVG_FIELD) avg_level = v;
               else rt_level = v;
            end else if (seps == fslp_pkg::SUM_FIELD) begin
               chk[7:4] = cnt > 0 ? nibble_of(fld[0]) : 4'd0;
               chk[3:0] = cnt > 1 ? nibble_of(fld[1]) : 4'd0;
               if (chk == sum) begin
                  apply_good_frame(speed);
                  res = fslp_pkg::RES_GOOD;
               end else begin
                  res = fslp_pkg::RES_BAD;
               end
            end
            cnt = 0;
         end
      end
      return res;
   endfunction

   function automatic fslp_pkg::rsp_type predict_word(input fslp_pkg::req_type r);
      fslp_pkg::rsp_type o;
      logic [2:0] res;
      res = fslp_pkg::RES_NONE;
      if (r.cmd) begin
         // Ticks only age a live connection.
         if (sensor_state != fslp_pkg::ST_DISCONNECTED) begin
            if (silent_ticks != 8'hff) silent_ticks++;
            if (silent_ticks > silence_max) begin
               sensor_state   = fslp_pkg::ST_DISCONNECTED;
               silent_ticks   = '0;
               abnormal_hits  = '0;
               slow_zero_hits = '0;
               alarm_bit      = 1'b0;
            end
         end
      end else if (r.rx_byte != fslp_pkg::LINE_END) begin
         // Bytes past the end of the store are dropped.
         if (line_fill < LINE_CAP) begin
            line_bytes[line_fill] = r.rx_byte;
            line_fill++;
         end
      end else begin
         res = parse_stored_line(r.vehicle_speed);
         line_fill = 0;
      end
      o.fuel_level     = fuel_level;
      o.average_level  = avg_level;
      o.realtime_level = rt_level;
      o.sensor_state   = sensor_state;
      o.fuel_alarm     = alarm_bit;
      o.frame_result   = res;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Acceptance, checking and the hang watchdog, all on the rising edge.
   // Block outputs still hold their pre-edge values here.
   // ------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      fslp_pkg::rsp_type want;
      fslp_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got = rsp_data;
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("ERROR: unexpected result word %p", got);
            end else begin
               want = expected_words.pop_front();
               if (got.fuel_level !== want.fuel_level
                   || got.average_level !== want.average_level
                   || got.realtime_level !== want.realtime_level
                   || got.sensor_state !== want.sensor_state
                   || got.fuel_alarm !== want.fuel_alarm
                   || got.frame_result !== want.frame_result) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("ERROR: result mismatch, expected %p, got %p", want, got);
               end
               if (!$isunknown(got.frame_result)) result_seen[got.frame_result]++;
               if (got.sensor_state === fslp_pkg::ST_ABNORMAL) abnormal_seen++;
            end
         end
         if (start && !busy) begin
            want = predict_word(req_data);
            expected_words.push_back(drive_typed ? drive_word : want);
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. Inputs change on the falling edge only.
   // ------------------------------------------------------------------
   task automatic send_word(input fslp_pkg::req_type r);
      int gap;
      gap = 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_data    <= r;
      drive_typed = use_typed;
      drive_word  = typed_word;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic send_tick();
      send_word('{cmd: 1'b1, rx_byte: 8'($urandom), vehicle_speed: 16'($urandom)});
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input logic [fslp_pkg::CSR_IDX_W-1:0] idx,
                                input logic [fslp_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         fslp_pkg::CSR_SPEED:   speed_limit    = val;
         fslp_pkg::CSR_ABN:     abnormal_max   = val[4:0];
         fslp_pkg::CSR_ZERO:    zero_clear_max = val[4:0];
         fslp_pkg::CSR_TIMEOUT: silence_max    = val[7:0];
         default: ;
      endcase
   endtask

   // A payload byte: anything but a separator or a line end.
   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == fslp_pkg::SEP_COMMA || b == fslp_pkg::SEP_HASH || b == fslp_pkg::LINE_END);
      return b;
   endfunction

   function automatic logic [7:0] pick_sep();
      return ($urandom_range(9) < 7) ? fslp_pkg::SEP_COMMA : fslp_pkg::SEP_HASH;
   endfunction

   function automatic void add_payload(input int n);
      for (int i = 0; i < n; i++) frame_bytes.push_back(payload_byte());
      frame_bytes.push_back(pick_sep());
   endfunction

   // A level field of five digits, now and then with a stray non-digit
   // or an extra trailing digit; a short field makes the parse abort.
   function automatic void add_level(input int val, input bit short_field);
      int n;
      int div;
      n   = short_field ? $urandom_range(0, 4) : 5;
      div = 10000;
      for (int i = 0; i < n; i++) begin
         frame_bytes.push_back(8'("0" + (val / div) % 10));
         div = div / 10;
      end
      if (!short_field && $urandom_range(9) == 0)
         frame_bytes[frame_bytes.size() - 1 - $urandom_range(4)] = "x";
      if (!short_field && $urandom_range(9) == 0) frame_bytes.push_back("7");
      frame_bytes.push_back(pick_sep());
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 10) return 8'("0" + n);
      return 8'((lower ? "a" : "A") + n - 10);
   endfunction

   function automatic int pick_level();
      case ($urandom_range(4))
         0: return 0;
         1: return 99999;
         2: return $urandom_range(1, 3);
         default: return $urandom_range(0, 99999);
      endcase
   endfunction

   // Builds one frame. Fields one to three are long enough that the
   // checksum covers only the header and those fields, so it can be
   // computed before the later fields are added.
   // flavor: 0 good, 1 bad checksum, 2 no closing checksum separator,
   // 3 short level field, 4 field too long.
   function automatic void build_frame(input int flavor);
      int         avg;
      int         rt;
      logic [7:0] sum;
      bit         lower;
      frame_bytes.delete();
      for (int i = 0; i < SCAN_FROM; i++) begin
         logic [7:0] b;
         do b = 8'($urandom); while (b == fslp_pkg::LINE_END);
         frame_bytes.push_back(b);
      end
      add_payload(flavor == 4 ? $urandom_range(31, 34) : $urandom_range(15, 20));
      add_payload($urandom_range(15, 20));
      add_payload($urandom_range(15, 20));
      avg = pick_level();
      case ($urandom_range(4))
         0, 1: rt = 0;
         2:    rt = avg;
         default: rt = pick_level();
      endcase
      add_level(avg, flavor == 3 && $urandom_range(1) == 0);
      for (int f = 5; f <= 9; f++) add_payload($urandom_range(0, 4));
      add_level(rt, flavor == 3);
      add_payload($urandom_range(0, 4));
      sum = '0;
      for (int i = 0; i < SUM_SPAN; i++) sum += frame_bytes[i];
      if (flavor == 1) sum ^= 8'($urandom_range(1, 255));
      lower = $urandom_range(1);
      frame_bytes.push_back(hex_char(sum[7:4], lower));
      frame_bytes.push_back(hex_char(sum[3:0], lower));
      if ($urandom_range(4) == 0) frame_bytes.push_back(payload_byte());
      if (flavor != 2) begin
         frame_bytes.push_back(pick_sep());
         if ($urandom_range(4) == 0) add_payload($urandom_range(0, 4));
      end
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hffff;
         2: return speed_limit;
         3: return speed_limit + 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_line();
      foreach (frame_bytes[i])
         send_word('{cmd: 1'b0, rx_byte: frame_bytes[i], vehicle_speed: 16'($urandom)});
      send_word('{cmd: 1'b0, rx_byte: fslp_pkg::LINE_END, vehicle_speed: pick_speed()});
   endtask

   // One group of random traffic: a frame or a noise line, then some ticks.
   task automatic send_random_group();
      int sel;
      int n;
      sel = $urandom_range(19);
      if (sel < 12) build_frame(0);
      else if (sel < 14) build_frame(1);
      else if (sel < 15) build_frame(2);
      else if (sel < 16) build_frame(3);
      else if (sel < 17) build_frame(4);
      else begin
         // Noise, sometimes long enough to overflow the line store.
         frame_bytes.delete();
         n = ($urandom_range(3) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 20);
         for (int i = 0; i < n; i++) begin
            logic [7:0] b;
            do b = 8'($urandom); while (b == fslp_pkg::LINE_END);
            frame_bytes.push_back(b);
         end
      end
      send_line();
      n = $urandom_range(0, 2);
      // Now and then stay silent long enough for the connection to time out.
      if (silence_max < 8'd130 && $urandom_range(19) == 0) n = silence_max + 2;
      repeat (n) send_tick();
   endtask

   // ------------------------------------------------------------------
   // Directed words: each row can carry its expected word when it is
   // obvious, i.e. everything still at its reset value.
   // ------------------------------------------------------------------
   typedef struct {
      fslp_pkg::req_type word;
      logic [2:0] result;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic void add_row(input logic c, input logic [7:0] b,
                                   input logic [15:0] s, input logic [2:0] res);
      dir_rows.push_back('{word: '{cmd: c, rx_byte: b, vehicle_speed: s}, result: res});
   endfunction

   initial begin
      int setting_pass;
      int n_frames;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      use_typed = 0;
      typed_word = '0;
      drive_typed = 0;
      drive_word = '0;
      idle_pct  = 0;
      errors    = 0;
      words_sent = 0;
      quiet_cycles = 0;
      abnormal_seen = 0;
      foreach (result_seen[i]) result_seen[i] = 0;
      clear_prediction();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Ticks while disconnected, extreme bytes and speeds, a line end on
      // a short line and on an empty one, and a level field left empty.
      add_row(1'b1, 8'h00, 16'h0000, fslp_pkg::RES_NONE);
      add_row(1'b1, 8'hff, 16'hffff, fslp_pkg::RES_NONE);
      add_row(1'b0, 8'h00, 16'hffff, fslp_pkg::RES_NONE);
      add_row(1'b0, 8'hff, 16'h0000, fslp_pkg::RES_NONE);
      add_row(1'b0, fslp_pkg::LINE_END, 16'hffff, fslp_pkg::RES_NOSUM);
      add_row(1'b0, fslp_pkg::LINE_END, 16'h0000, fslp_pkg::RES_NOSUM);
      for (int i = 0; i < SCAN_FROM; i++) add_row(1'b0, "$", 16'd0, fslp_pkg::RES_NONE);
      repeat (4) add_row(1'b0, fslp_pkg::SEP_COMMA, 16'd0, fslp_pkg::RES_NONE);
      add_row(1'b0, fslp_pkg::LINE_END, 16'h8000, fslp_pkg::RES_ABORT);
      foreach (dir_rows[i]) begin
         use_typed = 1;
         typed_word = '{fuel_level: '0, average_level: '0, realtime_level: '0,
                        sensor_state: fslp_pkg::ST_DISCONNECTED, fuel_alarm: 1'b0,
                        frame_result: dir_rows[i].result};
         send_word(dir_rows[i].word);
      end
      use_typed = 0;

      // Random traffic under four settings: the defaults, all minimums,
      // maximum or near-maximum values and a random mix, with varying sender idling.
      for (setting_pass = 0; setting_pass < 4; setting_pass++) begin
         if (setting_pass > 0) begin
            drain_and_settle();
            case (setting_pass)
               1: begin
                  write_setting(fslp_pkg::CSR_SPEED, 16'd0);
                  write_setting(fslp_pkg::CSR_ABN, 16'd0);
                  write_setting(fslp_pkg::CSR_ZERO, 16'd0);
                  write_setting(fslp_pkg::CSR_TIMEOUT, 16'd0);
               end
               2: begin
                  write_setting(fslp_pkg::CSR_SPEED, 16'hffff);
                  write_setting(fslp_pkg::CSR_ABN, 16'd30);
                  write_setting(fslp_pkg::CSR_ZERO, 16'd30);
                  write_setting(fslp_pkg::CSR_TIMEOUT, 16'd254);
               end
               default: begin
                  write_setting(fslp_pkg::CSR_SPEED, 16'($urandom_range(0, 2000)));
                  write_setting(fslp_pkg::CSR_ABN, 16'($urandom_range(0, 4)));
                  write_setting(fslp_pkg::CSR_ZERO, 16'($urandom_range(0, 4)));
                  write_setting(fslp_pkg::CSR_TIMEOUT, 16'($urandom_range(0, 10)));
               end
            endcase
         end
         case (setting_pass)
            0: idle_pct = 0;
            1: idle_pct = 74;
            2: idle_pct = 18;
            default: idle_pct = 0;
         endcase
         while (words_sent < dir_rows.size() + WORDS_PER_PHASE * (setting_pass + 1))
            send_random_group();
      end

      drain_and_settle();
      n_frames = result_seen[fslp_pkg::RES_GOOD] + result_seen[fslp_pkg::RES_BAD]
                 + result_seen[fslp_pkg::RES_ABORT] + result_seen[fslp_pkg::RES_NOSUM];
      $display("Sent %0d words under four settings; %0d line ends parsed.",
               words_sent, n_frames);
      $display("Frames good %0d, bad %0d, aborted %0d, no checksum %0d; abnormal words %0d.",
               result_seen[fslp_pkg::RES_GOOD], result_seen[fslp_pkg::RES_BAD],
               result_seen[fslp_pkg::RES_ABORT], result_seen[fslp_pkg::RES_NOSUM],
               abnormal_seen);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d words never returned", errors, expected_words.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
